// File: rtl/keypad_integer_calculator_unit_defines.svh
// Assertion macros shared by the calculator modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef KEYPAD_INTEGER_CALCULATOR_UNIT_DEFINES_SVH
`define KEYPAD_INTEGER_CALCULATOR_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KIC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KIC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/kic_pkg.sv
package kic_pkg;

    // Key codes of the operator and '=' keys, and the highest digit code.
    localparam logic [7:0] KEY_PLUS  = 8'h2B;
    localparam logic [7:0] KEY_MINUS = 8'h2D;
    localparam logic [7:0] KEY_TIMES = 8'h2A;
    localparam logic [7:0] KEY_DIV   = 8'h2F;
    localparam logic [7:0] KEY_EQ    = 8'h3D;
    localparam logic [7:0] KEY_MAX_DIGIT = 8'd9;

    // Pending arithmetic operation.
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // Class of a key code.
    typedef enum logic [1:0] {
        KIND_DIGIT = 2'd0,
        KIND_OPER  = 2'd1,
        KIND_EQ    = 2'd2,
        KIND_OTHER = 2'd3
    } key_kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic digit_a;   // append a digit to the first operand
        logic digit_b;   // append a digit to the second operand
        logic set_op;    // latch the operator key
        logic start;     // prepare the iterative unit
        logic step;      // run one iteration when needed
        logic load_out;  // load the output register
        logic clear;     // clear operands and operator
    } kic_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;      // the result is ready to load
        logic dbz;       // pending divide with a zero divisor
    } kic_status_t;

    // Classify a key code.
    function automatic key_kind_t key_kind(input logic [7:0] code);
        key_kind_t kind;
        kind = KIND_OTHER;
        if (code <= KEY_MAX_DIGIT)
            kind = KIND_DIGIT;
        else if (code == KEY_PLUS || code == KEY_MINUS ||
                 code == KEY_TIMES || code == KEY_DIV)
            kind = KIND_OPER;
        else if (code == KEY_EQ)
            kind = KIND_EQ;
        return kind;
    endfunction

    // Map an operator key to its operation.
    function automatic op_t key_op(input logic [7:0] code);
        op_t op;
        op = OP_ADD;
        if (code == KEY_MINUS)
            op = OP_SUB;
        else if (code == KEY_TIMES)
            op = OP_MUL;
        else if (code == KEY_DIV)
            op = OP_DIV;
        return op;
    endfunction

endpackage

// File: rtl/kic_ctrl.sv
`include "keypad_integer_calculator_unit_defines.svh"

module kic_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 key_valid,
    output logic                 key_stall,
    input  logic [7:0]           key_code,
    output logic                 res_valid,
    input  logic                 res_stall,
    input  kic_pkg::kic_status_t status,
    output kic_pkg::kic_cmd_t    cmd
);

    import kic_pkg::*;

    typedef enum logic [3:0] {
        ST_ENTRY_A = 4'b0001,
        ST_ENTRY_B = 4'b0010,
        ST_CALC    = 4'b0100,
        ST_LOCKED  = 4'b1000
    } state_t;

    state_t    state_reg;
    state_t    state_next;
    logic      res_valid_reg;
    logic      res_valid_next;
    logic      accept;
    logic      slot_free;
    key_kind_t kind;

    // Keys are taken in every phase but the calculation.
    assign key_stall = (state_reg == ST_CALC);
    assign accept    = key_valid && !key_stall;
    assign kind      = key_kind(key_code);
    assign slot_free = !res_valid_reg || !res_stall;
    assign res_valid = res_valid_reg;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_ENTRY_A:
            begin
                if (accept && kind == KIND_DIGIT)
                    cmd.digit_a = 1'b1;
                if (accept && kind == KIND_OPER)
                begin
                    cmd.set_op = 1'b1;
                    state_next = ST_ENTRY_B;
                end
            end
            ST_ENTRY_B:
            begin
                if (accept && kind == KIND_DIGIT)
                    cmd.digit_b = 1'b1;
                if (accept && kind == KIND_EQ)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.step = 1'b1;
                if (status.done && slot_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = status.dbz ? ST_LOCKED : ST_ENTRY_A;
                end
            end
            ST_LOCKED:
            begin
                state_next = ST_LOCKED;
            end
            default:
            begin
                state_next = ST_LOCKED;
            end
        endcase
    end

    // The output slot fills on a load and empties when a transaction completes.
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;
        if (cmd.load_out)
            res_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ENTRY_A;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // A result never overwrites one that is still waiting.
    `KIC_ASSERT_SAME(a_load_slot_free, cmd.load_out, !res_valid_reg || !res_stall, "load into a full output slot")
    // A division by zero leads into the locked phase.
    `KIC_ASSERT_NEXT(a_dbz_locks, cmd.load_out && status.dbz, state_reg == ST_LOCKED, "no lock after division by zero")
    // The locked phase is never left before reset.
    `KIC_ASSERT_NEXT(a_lock_holds, state_reg == ST_LOCKED, state_reg == ST_LOCKED, "left the locked phase")

endmodule

// File: rtl/kic_dp.sv
`include "keypad_integer_calculator_unit_defines.svh"

module kic_dp
#(
    parameter int W = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           key_code,
    input  kic_pkg::kic_cmd_t    cmd,
    output kic_pkg::kic_status_t status,
    output logic [31:0]          value,
    output logic                 div_by_zero
);

    import kic_pkg::*;

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     a_reg;
    logic [W-1:0]     a_next;
    logic [W-1:0]     b_reg;
    logic [W-1:0]     b_next;
    logic [W-1:0]     acc_reg;
    logic [W-1:0]     acc_next;
    op_t              op_reg;
    op_t              op_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [31:0]      value_reg;
    logic [31:0]      value_next;
    logic             dbz_reg;
    logic             dbz_next;

    logic [W-1:0]     digit;
    logic [W-1:0]     a_times_ten;
    logic [W-1:0]     b_times_ten;
    logic [W:0]       rem_shift;
    logic [W:0]       rem_diff;
    logic             rem_ge;
    logic             iter_op;
    logic             iter_done;
    logic             dbz;
    logic [W-1:0]     result;
    logic [W+31:0]    result_ext;

    // Decimal digit entry: times ten as two shifted copies plus the digit.
    assign digit       = {{(W-4){1'b0}}, key_code[3:0]};
    assign a_times_ten = {a_reg[W-4:0], 3'b000} + {a_reg[W-2:0], 1'b0};
    assign b_times_ten = {b_reg[W-4:0], 3'b000} + {b_reg[W-2:0], 1'b0};

    // One restoring divide step: quotient bits shift into the first operand.
    assign rem_shift = {acc_reg, a_reg[W-1]};
    assign rem_diff  = rem_shift - {1'b0, b_reg};
    assign rem_ge    = (rem_shift >= {1'b0, b_reg});

    // Status toward the controller.
    assign iter_op   = (op_reg == OP_MUL) || (op_reg == OP_DIV);
    assign dbz       = (op_reg == OP_DIV) && (b_reg == '0);
    assign iter_done = (cnt_reg == CNT_W'(W));
    assign status.dbz  = dbz;
    assign status.done = !iter_op || dbz || iter_done;

    // Final result selection.
    always_comb
    begin
        case (op_reg)
            OP_ADD:  result = a_reg + b_reg;
            OP_SUB:  result = a_reg - b_reg;
            OP_MUL:  result = acc_reg;
            default: result = a_reg;
        endcase
    end

    assign result_ext = {32'd0, result};

    // Operand, iteration and output register updates.
    always_comb
    begin
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        value_next = value_reg;
        dbz_next   = dbz_reg;

        if (cmd.digit_a)
            a_next = a_times_ten + digit;
        if (cmd.digit_b)
            b_next = b_times_ten + digit;
        if (cmd.set_op)
            op_next = key_op(key_code);
        if (cmd.start)
        begin
            acc_next = '0;
            cnt_next = '0;
        end

        // One multiply or divide iteration per cycle.
        if (cmd.step && iter_op && !dbz && !iter_done)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (op_reg == OP_MUL)
            begin
                acc_next = acc_reg + (b_reg[0] ? a_reg : '0);
                a_next   = {a_reg[W-2:0], 1'b0};
                b_next   = {1'b0, b_reg[W-1:1]};
            end
            else
            begin
                acc_next = rem_ge ? rem_diff[W-1:0] : rem_shift[W-1:0];
                a_next   = {a_reg[W-2:0], rem_ge};
            end
        end

        if (cmd.load_out)
        begin
            value_next = dbz ? 32'd0 : result_ext[31:0];
            dbz_next   = dbz;
        end

        if (cmd.clear)
        begin
            a_next  = '0;
            b_next  = '0;
            op_next = OP_ADD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg   <= '0;
            b_reg   <= '0;
            op_reg  <= OP_ADD;
            cnt_reg <= '0;
        end
        else
        begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            op_reg  <= op_next;
            cnt_reg <= cnt_next;
        end
    end

    // Payload registers without reset.
    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        value_reg <= value_next;
        dbz_reg   <= dbz_next;
    end

    assign value       = value_reg;
    assign div_by_zero = dbz_reg;

    // The iteration count never runs past the operand width.
    `KIC_ASSERT_SAME(a_cnt_range, 1'b1, cnt_reg <= CNT_W'(W), "iteration count out of range")
    // A division-by-zero result carries a zero value.
    `KIC_ASSERT_NEXT(a_dbz_value, cmd.load_out && dbz, value_reg == 32'd0 && dbz_reg, "bad division-by-zero result")

endmodule

// File: rtl/keypad_integer_calculator_unit.sv
// Channel   Valid      Stall      Payload
// key       key_valid  key_stall  key_code
// result    res_valid  res_stall  value, div_by_zero
//
// Digit and operator keys may follow back to back, with no stall between them.
// The '=' key starts the calculation: add, subtract and a division by zero need
// no iterations, while multiply and divide run on the one-bit-per-cycle
// shift-add/restoring unit. A result still waiting in the output slot adds its wait.
// Keys are stalled only while a calculation runs or waits for the output slot.
// Reset clears the operands and phase; after a division by zero every key is
// taken and dropped until reset.

module keypad_integer_calculator_unit
#(
    parameter int OPERAND_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               key_valid,
    output logic               key_stall,
    input  logic [7:0]         key_code,
    output logic               res_valid,
    input  logic               res_stall,
    output logic signed [31:0] value,
    output logic               div_by_zero
);

    import kic_pkg::*;

    kic_cmd_t    cmd;
    kic_status_t status;
    logic [31:0] value_raw;

    // Phase sequencing and handshakes.
    kic_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (key_valid),
        .key_stall (key_stall),
        .key_code  (key_code),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Operands, iterative unit and output register.
    kic_dp #(.W(OPERAND_BITS)) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .key_code    (key_code),
        .cmd         (cmd),
        .status      (status),
        .value       (value_raw),
        .div_by_zero (div_by_zero)
    );

    assign value = $signed(value_raw);

endmodule

// File: tb/calculator_checker.sv
module calculator_checker
#(
    parameter int OPERAND_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               key_valid,
    input  logic               key_stall,
    input  logic [7:0]         key_code,
    input  logic               res_valid,
    input  logic               res_stall,
    input  logic signed [31:0] value,
    input  logic               div_by_zero,
    output int                 fails,
    output int                 outstanding,
    output int                 keys_taken,
    output int                 results_checked
);

    import kic_pkg::*;

    // Entry phase of the calculator as the checker tracks it.
    typedef enum logic [1:0] {
        ENTER_FIRST  = 2'd0,
        ENTER_SECOND = 2'd1,
        LOCKED_OUT   = 2'd2
    } entry_phase_t;

    // One result the block owes us.
    typedef struct {
        logic signed [31:0] value;
        logic               div_by_zero;
    } calc_result_t;

    entry_phase_t              entry_phase;
    logic [OPERAND_BITS-1:0]   first_operand;
    logic [OPERAND_BITS-1:0]   second_operand;
    op_t                       pending_op;
    calc_result_t              owed_results[$];

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        fails++;
    endtask

    // Advance the calculator state by one accepted key and queue any result.
    task automatic apply_key(input logic [7:0] code);
        calc_result_t            res;
        logic [OPERAND_BITS-1:0] full;
        logic [63:0]             wide;
        case (entry_phase)
            ENTER_FIRST:
            begin
                if (code <= KEY_MAX_DIGIT)
                    first_operand = first_operand * 10 + code;
                else if (code == KEY_PLUS || code == KEY_MINUS ||
                         code == KEY_TIMES || code == KEY_DIV)
                begin
                    if (code == KEY_PLUS)
                        pending_op = OP_ADD;
                    else if (code == KEY_MINUS)
                        pending_op = OP_SUB;
                    else if (code == KEY_TIMES)
                        pending_op = OP_MUL;
                    else
                        pending_op = OP_DIV;
                    entry_phase = ENTER_SECOND;
                end
            end
            ENTER_SECOND:
            begin
                if (code <= KEY_MAX_DIGIT)
                    second_operand = second_operand * 10 + code;
                else if (code == KEY_EQ)
                begin
                    if (pending_op == OP_DIV && second_operand == '0)
                    begin
                        // A zero divisor reports an error and freezes the block.
                        res.value = '0;
                        res.div_by_zero = 1'b1;
                        owed_results.push_back(res);
                        entry_phase = LOCKED_OUT;
                    end
                    else
                    begin
                        case (pending_op)
                            OP_ADD:  full = first_operand + second_operand;
                            OP_SUB:  full = first_operand - second_operand;
                            OP_MUL:  full = first_operand * second_operand;
                            default: full = first_operand / second_operand;
                        endcase
                        wide = 64'(full);
                        res.value = wide[31:0];
                        res.div_by_zero = 1'b0;
                        owed_results.push_back(res);
                        first_operand = '0;
                        second_operand = '0;
                        pending_op = OP_ADD;
                        entry_phase = ENTER_FIRST;
                    end
                end
            end
            default:
            begin
                // Locked: every key is dropped.
            end
        endcase
    endtask

    // Sample both channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        calc_result_t want;
        if (!rst_n)
        begin
            entry_phase = ENTER_FIRST;
            first_operand = '0;
            second_operand = '0;
            pending_op = OP_ADD;
            owed_results.delete();
            outstanding <= 0;
        end
        else
        begin
            // Compare a result transaction with the oldest owed result.
            if (res_valid && !res_stall)
            begin
                results_checked++;
                if (owed_results.size() == 0)
                    report_mismatch($sformatf("result %0d/%0b arrived with none expected",
                                              value, div_by_zero));
                else
                begin
                    want = owed_results.pop_front();
                    if (value !== want.value)
                        report_mismatch($sformatf("value is %0d, expected %0d",
                                                  value, want.value));
                    if (div_by_zero !== want.div_by_zero)
                        report_mismatch($sformatf("div_by_zero is %0b, expected %0b",
                                                  div_by_zero, want.div_by_zero));
                end
            end

            // Feed each key transaction to the prediction.
            if (key_valid && !key_stall)
            begin
                keys_taken++;
                apply_key(key_code);
            end

            outstanding <= owed_results.size();
        end
    end

endmodule

// File: tb/tb.sv
module tb;
    import kic_pkg::*;

    localparam int OPERAND_BITS = 32;
    localparam int ITEM_TARGET  = 600;
    localparam int SETTLE_CYCLES = OPERAND_BITS + 20;
    localparam logic [7:0] NO_KEY = 8'hFF;

    // Modes of the result-side stall pattern.
    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_mode_t;

    logic               clk;
    logic               rst_n;
    logic               key_valid;
    logic               key_stall;
    logic [7:0]         key_code;
    logic               res_valid;
    logic               res_stall;
    logic signed [31:0] value;
    logic               div_by_zero;

    int fail_count;
    int results_outstanding;
    int keys_taken;
    int results_checked;

    int burst_left;
    int keys_sent;
    int ignored_sent;

    // Opening sequence: no-key code, '=' and an operator where they are ignored,
    // an empty second operand, an empty first operand and one of each operation.
    logic [7:0] opening_keys [0:19] = '{
        NO_KEY, KEY_EQ, 8'd0, 8'd9, KEY_PLUS, KEY_MINUS, KEY_EQ,
        KEY_MINUS, 8'd1, KEY_EQ,
        8'd7, KEY_TIMES, 8'h80, 8'd6, KEY_EQ,
        8'd9, 8'd5, KEY_DIV, 8'd2, KEY_EQ
    };

    keypad_integer_calculator_unit #(
        .OPERAND_BITS(OPERAND_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .key_valid(key_valid),
        .key_stall(key_stall),
        .key_code(key_code),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .value(value),
        .div_by_zero(div_by_zero)
    );

    calculator_checker #(
        .OPERAND_BITS(OPERAND_BITS)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .key_valid(key_valid),
        .key_stall(key_stall),
        .key_code(key_code),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .value(value),
        .div_by_zero(div_by_zero),
        .fails(fail_count),
        .outstanding(results_outstanding),
        .keys_taken(keys_taken),
        .results_checked(results_checked)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the handshakes hang.
    initial
    begin
        #(12 * 400000);
        $display("FAILED: results differ");
        $finish;
    end

    // Result-side stall, switching between patterns after a random span.
    initial
    begin
        stall_mode_t mode;
        int span;
        res_stall <= 1'b0;
        forever
        begin
            mode = stall_mode_t'($urandom_range(0, 3));
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    STALL_NONE:  res_stall <= 1'b0;
                    STALL_HALF:  res_stall <= 1'($urandom_range(0, 1));
                    STALL_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
                    default:     res_stall <= ~res_stall;
                endcase
            end
        end
    end

    // Send one key transaction; bursts end with a random gap.
    task automatic send_key(input logic [7:0] code);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                key_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        keys_sent++;
        key_valid <= 1'b1;
        key_code <= code;
        @(posedge clk);
        while (key_stall)
            @(posedge clk);
    endtask

    // Hold off the key side until every owed result has been returned.
    task automatic drain_results();
        if (key_valid)
            key_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (results_outstanding != 0)
            @(posedge clk);
    endtask

    // A key that the first phase drops: anything but a digit or an operator.
    function automatic logic [7:0] first_phase_junk();
        logic [7:0] code;
        code = 8'($urandom_range(10, 255));
        while (code == KEY_PLUS || code == KEY_MINUS || code == KEY_TIMES ||
               code == KEY_DIV)
            code = 8'($urandom_range(10, 255));
        return code;
    endfunction

    // A key that the second phase drops: anything but a digit or '='.
    function automatic logic [7:0] second_phase_junk();
        logic [7:0] code;
        code = 8'($urandom_range(10, 255));
        while (code == KEY_EQ)
            code = 8'($urandom_range(10, 255));
        return code;
    endfunction

    function automatic logic [7:0] operator_key(input op_t op);
        case (op)
            OP_ADD:  return KEY_PLUS;
            OP_SUB:  return KEY_MINUS;
            OP_MUL:  return KEY_TIMES;
            default: return KEY_DIV;
        endcase
    endfunction

    // Mostly short operands, now and then long enough to wrap.
    function automatic int digit_count();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 3);
    endfunction

    // Type a random decimal operand and return what it accumulates to.
    task automatic send_operand(input int count, output logic [OPERAND_BITS-1:0] acc);
        logic [7:0] digit;
        acc = '0;
        repeat (count)
        begin
            digit = 8'($urandom_range(0, 9));
            acc = acc * 10 + digit;
            send_key(digit);
        end
    endtask

    // One well-formed calculation with occasional dropped keys mixed in.
    task automatic run_calculation(input op_t op);
        logic [OPERAND_BITS-1:0] lhs;
        logic [OPERAND_BITS-1:0] rhs;
        send_operand(digit_count(), lhs);
        if ($urandom_range(0, 9) == 0)
        begin
            send_key(first_phase_junk());
            ignored_sent++;
        end
        send_key(operator_key(op));
        if ($urandom_range(0, 9) == 0)
        begin
            send_key(second_phase_junk());
            ignored_sent++;
        end
        send_operand(digit_count(), rhs);
        // A zero divisor locks the block, so it is kept for the very end.
        if (op == OP_DIV && rhs == '0)
            send_key(8'd1);
        send_key(KEY_EQ);
    endtask

    // Reset, directed opening, random calculations, then the lockout.
    initial
    begin
        rst_n <= 1'b0;
        key_valid <= 1'b0;
        key_code <= NO_KEY;
        burst_left = 0;
        keys_sent = 0;
        ignored_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_keys[i])
            send_key(opening_keys[i]);
        drain_results();
        keys_sent = 0;

        while (keys_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 99) < 80)
                run_calculation(op_t'($urandom_range(0, 3)));
            else
            begin
                send_key(first_phase_junk());
                ignored_sent++;
            end
            if ($urandom_range(0, 14) == 0)
                drain_results();
        end
        drain_results();

        // Division by a zero divisor, typed or left empty, then a locked block.
        send_key(8'd8);
        send_key(KEY_DIV);
        if ($urandom_range(0, 1) == 1)
            send_key(8'd0);
        send_key(KEY_EQ);
        send_key(8'd3);
        send_key(KEY_PLUS);
        send_key(8'd4);
        send_key(KEY_EQ);
        send_key(KEY_DIV);
        send_key(KEY_EQ);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Summary: %0d keys accepted and %0d results checked.",
                 keys_taken, results_checked);
        $display("Covered: all four operations, wrapping operands, %0d dropped keys, lockout.",
                 ignored_sent);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/kic_pkg.sv
rtl/kic_ctrl.sv
rtl/kic_dp.sv
rtl/keypad_integer_calculator_unit.sv
tb/calculator_checker.sv
tb/tb.sv
